FILE: rtl/pt4_pkg.sv
// Shared types and constants for the 4x4 point transform unit.
// No dependencies; used by pt4_ctrl, pt4_datapath and the top level.
`default_nettype none

package pt4_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + 2;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_MUL   = 2'd1;
   localparam logic [1:0] MODE_MULT  = 2'd2;
   localparam logic [1:0] MODE_RIGID = 2'd3;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   // controller -> datapath commands
   typedef struct packed {
      logic       load;      // write one matrix entry from the request
      logic       capture;   // latch the request vector
      logic       issue;     // start one product
      logic [1:0] a_row;     // matrix operand row
      logic [1:0] a_col;     // matrix operand column
      logic [1:0] b_idx;     // vector / temp operand index
      logic       b_from_t;  // vector operand from temp vector
      logic       first;     // first term of a sum
      logic       last;      // last term of a sum
      logic       sub;       // acc = v[dest] * 2^16 - product
      logic [1:0] dest;      // result element
      logic       dest_t;    // result goes to temp vector
      logic       publish;   // load response register
      logic       pass_w;    // out_w takes vec_w unchanged
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic busy;            // products still in flight
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: rtl/pt4_ctrl.sv
// Sequencer for the 4x4 point transform: walks the row/column terms.
// Depends on pt4_pkg.
`default_nettype none

module pt4_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pt4_pkg::dp_cmd_type    cmd,
   input  wire pt4_pkg::dp_stat_type stat
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_PUBLISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic       phase_ff, phase_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] col_ff, col_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       req_xfer;
   logic [1:0] col_max;
   logic [1:0] row_max;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      // term and row bounds per mode / phase
      if (mode_ff == pt4_pkg::MODE_RIGID) begin
         col_max = phase_ff ? 2'd2 : 2'd0;
         row_max = 2'd2;
      end else begin
         col_max = 2'd3;
         row_max = 2'd3;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_mode == pt4_pkg::MODE_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  mode_in     = req_mode;
                  phase_in    = 1'b0;
                  row_in      = 2'd0;
                  col_in      = 2'd0;
                  state_in    = S_RUN;
               end
            end
         end
         S_RUN: begin
            cmd.issue = 1'b1;
            cmd.dest  = row_ff;
            cmd.first = (col_ff == 2'd0);
            cmd.last  = (col_ff == col_max);
            cmd.b_idx = col_ff;
            cmd.a_row = col_ff;
            cmd.a_col = row_ff;
            case (mode_ff)
               pt4_pkg::MODE_MUL: begin
                  cmd.a_row = row_ff;
                  cmd.a_col = col_ff;
               end
               pt4_pkg::MODE_RIGID: begin
                  if (!phase_ff) begin
                     // translation term: M(i,3) * w
                     cmd.a_row  = row_ff;
                     cmd.a_col  = 2'd3;
                     cmd.b_idx  = 2'd3;
                     cmd.sub    = 1'b1;
                     cmd.dest_t = 1'b1;
                  end else begin
                     cmd.b_from_t = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (col_ff == col_max) begin
               col_in = 2'd0;
               if (row_ff == row_max) begin
                  state_in = S_DRAIN;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            if (!stat.busy) begin
               if (mode_ff == pt4_pkg::MODE_RIGID && !phase_ff) begin
                  phase_in = 1'b1;
                  row_in   = 2'd0;
                  col_in   = 2'd0;
                  state_in = S_RUN;
               end else begin
                  state_in = S_PUBLISH;
               end
            end
         end
         S_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               cmd.pass_w   = (mode_ff == pt4_pkg::MODE_RIGID);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= pt4_pkg::MODE_LOAD;
         phase_ff     <= 1'b0;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pt4_datapath.sv
// Datapath for the 4x4 point transform: matrix store, one multiplier,
// accumulator, floor/saturate and response register. Depends on pt4_pkg.
`default_nettype none

module pt4_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pt4_pkg::dp_cmd_type                 cmd,
   output pt4_pkg::dp_stat_type                     stat,
   input  wire logic [1:0]                          req_entry_row,
   input  wire logic [1:0]                          req_entry_col,
   input  wire logic signed [pt4_pkg::DATA_W-1:0]   req_entry_value,
   input  wire logic signed [pt4_pkg::DATA_W-1:0]   req_vec_x,
   input  wire logic signed [pt4_pkg::DATA_W-1:0]   req_vec_y,
   input  wire logic signed [pt4_pkg::DATA_W-1:0]   req_vec_z,
   input  wire logic signed [pt4_pkg::DATA_W-1:0]   req_vec_w,
   output logic signed [pt4_pkg::DATA_W-1:0]        rsp_out_x,
   output logic signed [pt4_pkg::DATA_W-1:0]        rsp_out_y,
   output logic signed [pt4_pkg::DATA_W-1:0]        rsp_out_z,
   output logic signed [pt4_pkg::DATA_W-1:0]        rsp_out_w
);

   localparam int DW = pt4_pkg::DATA_W;
   localparam int PW = pt4_pkg::PROD_W;
   localparam int AW = pt4_pkg::ACC_W;
   localparam int FW = pt4_pkg::FRAC_W;

   logic signed [DW-1:0] mat_ff [16];
   logic signed [DW-1:0] vec_ff [4];
   logic signed [DW-1:0] tmp_ff [3];
   logic signed [DW-1:0] res_ff [4];
   logic signed [DW-1:0] out_ff [4];

   // stage 1: product
   logic                 s1_valid_ff;
   logic                 s1_first_ff, s1_last_ff, s1_sub_ff, s1_dest_t_ff;
   logic [1:0]           s1_dest_ff;
   logic signed [PW-1:0] prod_ff;
   // stage 2: accumulate
   logic                 s2_done_ff;
   logic                 s2_dest_t_ff;
   logic [1:0]           s2_dest_ff;
   logic signed [AW-1:0] acc_ff, acc_in;

   logic signed [DW-1:0] a_op, b_op, t_sel, sat_val;
   logic signed [AW-1:0] prod_ext, v_init;

   assign stat.busy = s1_valid_ff || s2_done_ff;

   always_comb begin
      a_op = mat_ff[{cmd.a_row, cmd.a_col}];
      case (cmd.b_idx)
         2'd0:    t_sel = tmp_ff[0];
         2'd1:    t_sel = tmp_ff[1];
         2'd2:    t_sel = tmp_ff[2];
         default: t_sel = '0;
      endcase
      b_op = cmd.b_from_t ? t_sel : vec_ff[cmd.b_idx];
   end

   always_comb begin
      prod_ext = {{(AW-PW){prod_ff[PW-1]}}, prod_ff};
      v_init   = {{(AW-DW-FW){vec_ff[s1_dest_ff][DW-1]}}, vec_ff[s1_dest_ff], {FW{1'b0}}};
      if (s1_first_ff) begin
         acc_in = s1_sub_ff ? (v_init - prod_ext) : prod_ext;
      end else begin
         acc_in = acc_ff + prod_ext;
      end
   end

   // floor(acc / 2^16) fits 32 bits iff acc[AW-1:DW+FW-1] are all equal
   always_comb begin
      if ((&acc_ff[AW-1:DW+FW-1]) || !(|acc_ff[AW-1:DW+FW-1])) begin
         sat_val = acc_ff[DW+FW-1:FW];
      end else if (acc_ff[AW-1]) begin
         sat_val = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(DW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= ((i / 4) == (i % 4)) ? pt4_pkg::Q_ONE : '0;
         end
         s1_valid_ff <= 1'b0;
         s2_done_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            mat_ff[{req_entry_row, req_entry_col}] <= req_entry_value;
         end
         s1_valid_ff <= cmd.issue;
         s2_done_ff  <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         vec_ff[3] <= req_vec_w;
      end
      if (cmd.issue) begin
         prod_ff      <= a_op * b_op;
         s1_first_ff  <= cmd.first;
         s1_last_ff   <= cmd.last;
         s1_sub_ff    <= cmd.sub;
         s1_dest_ff   <= cmd.dest;
         s1_dest_t_ff <= cmd.dest_t;
      end
      if (s1_valid_ff) begin
         acc_ff       <= acc_in;
         s2_dest_ff   <= s1_dest_ff;
         s2_dest_t_ff <= s1_dest_t_ff;
      end
      if (s2_done_ff) begin
         if (s2_dest_t_ff) begin
            case (s2_dest_ff)
               2'd0:    tmp_ff[0] <= sat_val;
               2'd1:    tmp_ff[1] <= sat_val;
               default: tmp_ff[2] <= sat_val;
            endcase
         end else begin
            res_ff[s2_dest_ff] <= sat_val;
         end
      end
      if (cmd.publish) begin
         out_ff[0] <= res_ff[0];
         out_ff[1] <= res_ff[1];
         out_ff[2] <= res_ff[2];
         out_ff[3] <= cmd.pass_w ? vec_ff[3] : res_ff[3];
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_out_w = out_ff[3];

endmodule

`default_nettype wire

FILE: rtl/point_transform_4x4_unit.sv
// Top level of the 4x4 homogeneous point transform unit.
// Depends on pt4_pkg, pt4_ctrl and pt4_datapath.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+----------------------------------------
//   req_     | in  | req_valid/req_ready  | mode, entry_row/col/value, vec_x..vec_w
//   rsp_     | out | rsp_valid/rsp_ready  | out_x, out_y, out_z, out_w
//
// A load transfer writes one matrix entry in its accept cycle; the unit is
// ready again the next cycle. Multiply and transposed multiply issue 16
// products on the single 32x32 multiplier, then drain the pipeline and load
// the response register before the next request is taken. Rigid inverse
// issues 3 + 9 products with two drains. Synchronous active-high reset
// loads the identity matrix and empties the response register. A stalled
// response holds in its own register, so the next request transfer is
// taken while it waits.
`default_nettype none

module point_transform_4x4_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [1:0]                        req_entry_row,
   input  wire logic [1:0]                        req_entry_col,
   input  wire logic signed [pt4_pkg::DATA_W-1:0] req_entry_value,
   input  wire logic signed [pt4_pkg::DATA_W-1:0] req_vec_x,
   input  wire logic signed [pt4_pkg::DATA_W-1:0] req_vec_y,
   input  wire logic signed [pt4_pkg::DATA_W-1:0] req_vec_z,
   input  wire logic signed [pt4_pkg::DATA_W-1:0] req_vec_w,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [pt4_pkg::DATA_W-1:0]      rsp_out_x,
   output logic signed [pt4_pkg::DATA_W-1:0]      rsp_out_y,
   output logic signed [pt4_pkg::DATA_W-1:0]      rsp_out_z,
   output logic signed [pt4_pkg::DATA_W-1:0]      rsp_out_w
);

   pt4_pkg::dp_cmd_type  cmd;
   pt4_pkg::dp_stat_type stat;

   // sequencer: counts rows/terms and hands out one product per cycle in its run state
   pt4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // matrix store, multiplier, accumulator, floor/saturate, response regs
   pt4_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_entry_row   (req_entry_row),
      .req_entry_col   (req_entry_col),
      .req_entry_value (req_entry_value),
      .req_vec_x       (req_vec_x),
      .req_vec_y       (req_vec_y),
      .req_vec_z       (req_vec_z),
      .req_vec_w       (req_vec_w),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_w       (rsp_out_w)
   );

`ifndef SYNTHESIS
   // a load transfer never blocks the request side
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == pt4_pkg::MODE_LOAD) |=> req_ready)
      else $error("ready dropped after a load transfer");

   // a transform transfer starts work, so the request side closes
   a_xform_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode != pt4_pkg::MODE_LOAD) |=> !req_ready)
      else $error("ready held after a transform transfer");

   // a response only appears at the end of a transform
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while idle");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for point_transform_4x4_unit: drives load and transform
// transfers, predicts each result vector in Q16.16, and checks the response channel.
// Depends on pt4_pkg and the point_transform_4x4_unit RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int DATA_W = pt4_pkg::DATA_W;
   localparam int FRAC_W = pt4_pkg::FRAC_W;

   // Exact sums need 64-bit products plus carry room; 80 bits is plenty.
   localparam int WIDE_W = 80;
   localparam logic signed [WIDE_W-1:0] SAT_HI = 80'sh7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -80'sh8000_0000;
   localparam int STALL_LIMIT  = 3000;  // cycles with no transfer on either channel
   localparam int DRAIN_CYCLES = 40;    // idle time after the last expected result
   localparam int HOLD_OFF_LEN = 400;   // long response hold-off

   typedef struct {
      logic [1:0]               mode;
      logic [1:0]               row;
      logic [1:0]               col;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] x, y, z, w;
   } point_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] x, y, z, w;
   } point_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_mode = pt4_pkg::MODE_LOAD;
   logic [1:0]               req_entry_row = '0;
   logic [1:0]               req_entry_col = '0;
   logic signed [DATA_W-1:0] req_entry_value = '0;
   logic signed [DATA_W-1:0] req_vec_x = '0;
   logic signed [DATA_W-1:0] req_vec_y = '0;
   logic signed [DATA_W-1:0] req_vec_z = '0;
   logic signed [DATA_W-1:0] req_vec_w = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_x;
   logic signed [DATA_W-1:0] rsp_out_y;
   logic signed [DATA_W-1:0] rsp_out_z;
   logic signed [DATA_W-1:0] rsp_out_w;

   // Shadow copy of the matrix, updated as load transfers are accepted.
   logic signed [DATA_W-1:0] shadow_matrix [4][4];
   point_vec_type            expected_points [$];

   int error_count     = 0;
   int stall_cycles    = 0;
   int result_count    = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;

   point_transform_4x4_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_entry_row   (req_entry_row),
      .req_entry_col   (req_entry_col),
      .req_entry_value (req_entry_value),
      .req_vec_x       (req_vec_x),
      .req_vec_y       (req_vec_y),
      .req_vec_z       (req_vec_z),
      .req_vec_w       (req_vec_w),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_w       (rsp_out_w)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // floor(sum / 2^16), clamped to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] floor_sat(
         input logic signed [WIDE_W-1:0] sum);
      logic signed [WIDE_W-1:0] q;
      q = sum >>> FRAC_W;
      if (q > SAT_HI) return 32'sh7FFF_FFFF;
      if (q < SAT_LO) return 32'sh8000_0000;
      return q[DATA_W-1:0];
   endfunction

   function automatic point_vec_type transform_point(input point_req_type r);
      logic signed [WIDE_W-1:0] v [4];
      logic signed [WIDE_W-1:0] t [3];
      logic signed [WIDE_W-1:0] acc;
      logic signed [DATA_W-1:0] res [4];
      point_vec_type            p;
      v[0] = r.x;
      v[1] = r.y;
      v[2] = r.z;
      v[3] = r.w;
      if (r.mode == pt4_pkg::MODE_RIGID) begin
         // undo the translation (scaled by w), then apply the transposed 3x3
         for (int i = 0; i < 3; i++) begin
            acc  = (v[i] <<< FRAC_W) - WIDE_W'(shadow_matrix[i][3]) * v[3];
            t[i] = floor_sat(acc);
         end
         for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int j = 0; j < 3; j++)
               acc = acc + WIDE_W'(shadow_matrix[j][i]) * t[j];
            res[i] = floor_sat(acc);
         end
         res[3] = r.w;  // w passes through untouched
      end else begin
         for (int i = 0; i < 4; i++) begin
            acc = '0;
            for (int j = 0; j < 4; j++)
               acc = acc + WIDE_W'((r.mode == pt4_pkg::MODE_MUL) ? shadow_matrix[i][j]
                                                                 : shadow_matrix[j][i]) * v[j];
            res[i] = floor_sat(acc);
         end
      end
      p.x = res[0];
      p.y = res[1];
      p.z = res[2];
      p.w = res[3];
      return p;
   endfunction

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %h, want %h",
                                result_count, name, got, want));
   endtask

   // Sampled at the rising edge: responses are checked first, then the
   // request transfer of the same edge updates the shadow matrix or queues
   // its expected point.
   always @(posedge clock) begin
      point_vec_type want;
      point_req_type seen;
      if (reset) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               shadow_matrix[r][c] = (r == c) ? pt4_pkg::Q_ONE : '0;
         stall_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_error($sformatf("unexpected result %h %h %h %h",
                                      rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w));
            end else begin
               want = expected_points.pop_front();
               compare_field("out_x", rsp_out_x, want.x);
               compare_field("out_y", rsp_out_y, want.y);
               compare_field("out_z", rsp_out_z, want.z);
               compare_field("out_w", rsp_out_w, want.w);
            end
            result_count++;
         end
         if (req_valid && req_ready) begin
            if (req_mode == pt4_pkg::MODE_LOAD) begin
               shadow_matrix[req_entry_row][req_entry_col] = req_entry_value;
            end else begin
               seen.mode  = req_mode;
               seen.row   = req_entry_row;
               seen.col   = req_entry_col;
               seen.value = req_entry_value;
               seen.x     = req_vec_x;
               seen.y     = req_vec_y;
               seen.z     = req_vec_z;
               seen.w     = req_vec_w;
               expected_points.push_back(transform_point(seen));
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Watchdog: too long without any transfer means the unit is hung.
   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("point_transform_4x4_unit: mismatch");
      $finish;
   end

   // Response side: random stalls per phase, plus a counted hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Drives at the falling edge and returns at the rising edge of the transfer.
   // Valid stays up across back-to-back items; it only drops on an idle cycle.
   task automatic send_item(input point_req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_entry_row   <= it.row;
      req_entry_col   <= it.col;
      req_entry_value <= it.value;
      req_vec_x       <= it.x;
      req_vec_y       <= it.y;
      req_vec_z       <= it.z;
      req_vec_w       <= it.w;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Fields that the mode ignores are filled with noise.
   task automatic load_entry(input logic [1:0] row, input logic [1:0] col,
                             input logic signed [DATA_W-1:0] value);
      point_req_type it;
      it.mode  = pt4_pkg::MODE_LOAD;
      it.row   = row;
      it.col   = col;
      it.value = value;
      it.x     = $urandom;
      it.y     = $urandom;
      it.z     = $urandom;
      it.w     = $urandom;
      send_item(it);
   endtask

   task automatic send_transform(input logic [1:0] mode,
                                 input logic signed [DATA_W-1:0] x, y, z, w);
      point_req_type it;
      it.mode  = mode;
      it.row   = 2'($urandom);
      it.col   = 2'($urandom);
      it.value = $urandom;
      it.x     = x;
      it.y     = y;
      it.z     = z;
      it.w     = w;
      send_item(it);
   endtask

   // Mostly useful magnitudes, with raw bit patterns and the rails mixed in.
   function automatic logic signed [DATA_W-1:0] random_fixed();
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom;
         3, 4:    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         5: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         6:       return $urandom_range(0, 1) ? pt4_pkg::Q_ONE : -pt4_pkg::Q_ONE;
         default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   function automatic point_req_type random_item();
      point_req_type it;
      it.mode  = ($urandom_range(0, 9) < 3) ? pt4_pkg::MODE_LOAD
                                             : 2'($urandom_range(1, 3));
      it.row   = 2'($urandom);
      it.col   = 2'($urandom);
      it.value = random_fixed();
      it.x     = random_fixed();
      it.y     = random_fixed();
      it.z     = random_fixed();
      it.w     = random_fixed();
      return it;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Identity after reset: every transform mode should return the vector.
   task automatic test_identity_reset();
      send_transform(pt4_pkg::MODE_MUL, 32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000,
                     pt4_pkg::Q_ONE);
      send_transform(pt4_pkg::MODE_MULT, 32'shFFFF_FFFF, 32'sh0000_0001, -32'sh0000_8000,
                     pt4_pkg::Q_ONE);
      send_transform(pt4_pkg::MODE_RIGID, 32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000,
                     32'sh0002_0000);
   endtask

   // 90 degree turn about z plus a translation, then undo it.
   task automatic test_rigid_inverse();
      load_entry(2'd0, 2'd0, 32'sh0000_0000);
      load_entry(2'd0, 2'd1, -pt4_pkg::Q_ONE);
      load_entry(2'd1, 2'd0, pt4_pkg::Q_ONE);
      load_entry(2'd1, 2'd1, 32'sh0000_0000);
      load_entry(2'd0, 2'd3, 32'sh0005_0000);
      load_entry(2'd1, 2'd3, -32'sh0003_0000);
      load_entry(2'd2, 2'd3, 32'sh0000_4000);
      send_transform(pt4_pkg::MODE_RIGID, 32'sh0002_0000, pt4_pkg::Q_ONE, 32'sh0000_8000,
                     pt4_pkg::Q_ONE);
      send_transform(pt4_pkg::MODE_MUL, 32'sh0002_0000, pt4_pkg::Q_ONE, 32'sh0000_8000,
                     pt4_pkg::Q_ONE);
      send_transform(pt4_pkg::MODE_RIGID, 32'sh0002_0000, pt4_pkg::Q_ONE, 32'sh0000_8000,
                     -32'sh0001_8000);
   endtask

   // Rail entries and rail vectors: both saturation directions, also inside
   // the inverse's translation step with a matrix that is no longer rigid.
   task automatic test_saturation();
      load_entry(2'd0, 2'd0, 32'sh7FFF_FFFF);
      load_entry(2'd3, 2'd3, 32'sh8000_0000);
      send_transform(pt4_pkg::MODE_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF);
      send_transform(pt4_pkg::MODE_MULT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000);
      send_transform(pt4_pkg::MODE_RIGID, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                     32'sh7FFF_FFFF);
   endtask

   // Hold the response side off for a long stretch while requests keep
   // coming, so the unit fills up and drops req_ready.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (12)
         send_transform(2'($urandom_range(1, 3)), random_fixed(), random_fixed(),
                        random_fixed(), random_fixed());
   endtask

   task automatic test_random_stream(input int count, input int idle_pct,
                                     input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_item(random_item());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity_reset();
      test_rigid_inverse();
      test_saturation();
      test_backpressure();
      test_random_stream(350, 0, 0);
      test_random_stream(350, 62, 0);
      test_random_stream(350, 0, 62);
      test_random_stream(350, 33, 33);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("point_transform_4x4_unit: match");
      else
         $display("point_transform_4x4_unit: mismatch");
      $finish;
   end

endmodule
